### src/mmd_pkg.sv
package mmd_pkg;

  localparam int VAL_W     = 16;
  localparam int WGT_W     = 16;
  localparam int MUL_A_W   = 32;
  localparam int PROD_W    = 48;
  localparam int DSUM_W    = 54;
  localparam int WSUM_W    = 22;
  localparam int ROOT_W    = DSUM_W / 2;
  localparam int DIST_W    = 16;
  localparam int CAT_SHIFT = 24;

  localparam int MUL_CNT_W  = $clog2(WGT_W);
  localparam int DIV_CNT_W  = $clog2(DSUM_W);
  localparam int SQRT_CNT_W = $clog2(ROOT_W);

  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [DSUM_W-1:0] dsum_t;
  typedef logic [WSUM_W-1:0] wsum_t;
  typedef logic [ROOT_W-1:0] root_t;

endpackage

### src/mmd_mul.sv
module mmd_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mmd_pkg::MUL_A_W-1:0]     a,
  input  logic [mmd_pkg::WGT_W-1:0]       b,
  output logic                            done,
  output mmd_pkg::prod_t                  prod
);

  localparam logic [mmd_pkg::MUL_CNT_W-1:0] LastStep = mmd_pkg::MUL_CNT_W'(mmd_pkg::WGT_W - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [mmd_pkg::MUL_CNT_W-1:0] cnt_r;
  mmd_pkg::prod_t                a_r;
  mmd_pkg::prod_t                acc_r;
  logic [mmd_pkg::WGT_W-1:0]     b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LastStep);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) busy_r <= 1'b0;
      end
    end
  end

  // shift-add, one multiplier bit per cycle, lsb first
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mmd_pkg::PROD_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### src/mmd_div.sv
module mmd_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mmd_pkg::dsum_t dividend,
  input  mmd_pkg::wsum_t divisor,
  output logic           done,
  output mmd_pkg::dsum_t quot
);

  localparam logic [mmd_pkg::DIV_CNT_W-1:0] LastStep = mmd_pkg::DIV_CNT_W'(mmd_pkg::DSUM_W - 1);

  logic                          busy_r;
  logic                          done_r;
  logic [mmd_pkg::DIV_CNT_W-1:0] cnt_r;
  mmd_pkg::dsum_t                d_r;
  mmd_pkg::wsum_t                w_r;
  mmd_pkg::wsum_t                rem_r;
  logic [mmd_pkg::WSUM_W:0]      trial;
  logic                          fits;

  assign trial = {rem_r, d_r[mmd_pkg::DSUM_W-1]};
  assign fits  = trial >= {1'b0, w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LastStep);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) busy_r <= 1'b0;
      end
    end
  end

  // restoring divide, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      w_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) rem_r <= mmd_pkg::WSUM_W'(trial - {1'b0, w_r});
      else      rem_r <= trial[mmd_pkg::WSUM_W-1:0];
      d_r <= {d_r[mmd_pkg::DSUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = d_r;

endmodule

### src/mmd_sqrt.sv
module mmd_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mmd_pkg::dsum_t x,
  output logic           done,
  output mmd_pkg::root_t root
);

  localparam int RemW = mmd_pkg::ROOT_W + 1;
  localparam logic [mmd_pkg::SQRT_CNT_W-1:0] LastStep =
    mmd_pkg::SQRT_CNT_W'(mmd_pkg::ROOT_W - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [mmd_pkg::SQRT_CNT_W-1:0] cnt_r;
  mmd_pkg::dsum_t                 x_r;
  mmd_pkg::root_t                 q_r;
  logic [RemW-1:0]                r_r;
  logic [RemW+1:0]                r_sh;
  logic [RemW+1:0]                trial;
  logic                           fits;

  assign r_sh  = {r_r, x_r[mmd_pkg::DSUM_W-1 -: 2]};
  assign trial = {1'b0, q_r, 2'b01};
  assign fits  = r_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LastStep);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LastStep) busy_r <= 1'b0;
      end
    end
  end

  // one root bit per cycle, two radicand bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      q_r <= '0;
      r_r <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 2;
      if (fits) begin
        r_r <= RemW'(r_sh - trial);
        q_r <= {q_r[mmd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        r_r <= r_sh[RemW-1:0];
        q_r <= {q_r[mmd_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = q_r;

endmodule

### src/masked_mixed_distance.sv
// a skipped, missing or categorical column goes from accept through the add state and back to ready
// a contributing numeric column first runs two 16-step bit-serial multiplies
// a last column with a nonzero weight sum adds a 54-step divide, 27-step square root, result load
// one column in flight at a time; a finished result waits in the output register
// synchronous active-low reset clears both sums, the sequencer and out_valid
module masked_mixed_distance (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic signed [mmd_pkg::VAL_W-1:0] in_receiver_value,
  input  logic signed [mmd_pkg::VAL_W-1:0] in_donor_value,
  input  logic                             in_receiver_present,
  input  logic                             in_donor_present,
  input  logic [mmd_pkg::WGT_W-1:0]        in_weight,
  input  logic                             in_skip,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mmd_pkg::DIST_W-1:0]       out_distance,
  output logic                             out_infinite
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                  state_r;
  logic [mmd_pkg::WGT_W-1:0]   w_r;
  logic                        last_r;
  logic                        contrib_r;
  logic                        inf_r;
  mmd_pkg::prod_t              add_r;
  mmd_pkg::dsum_t              dsum_r;
  mmd_pkg::wsum_t              wsum_r;
  mmd_pkg::dsum_t              dsum_nxt;
  mmd_pkg::wsum_t              wsum_nxt;
  logic                        out_valid_r;
  logic [mmd_pkg::DIST_W-1:0]  out_distance_r;
  logic                        out_infinite_r;

  logic                        accept;
  logic                        contrib;
  logic                        numeric;
  logic [mmd_pkg::VAL_W:0]     diff;
  logic [mmd_pkg::VAL_W:0]     mag;
  logic [mmd_pkg::DSUM_W:0]    dsum_wide;
  logic [mmd_pkg::WSUM_W:0]    wsum_wide;
  logic                        emit;
  logic [mmd_pkg::DIST_W-1:0]  root_sat;

  logic                        mul_start;
  logic [mmd_pkg::MUL_A_W-1:0] mul_a;
  logic                        mul_done;
  mmd_pkg::prod_t              mul_prod;
  logic                        div_start;
  logic                        div_done;
  mmd_pkg::dsum_t              div_quot;
  logic                        sqrt_start;
  logic                        sqrt_done;
  mmd_pkg::root_t              sqrt_root;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign contrib  = !in_skip && (in_weight != '0) && in_receiver_present && in_donor_present;
  assign numeric  = contrib && !in_kind;

  assign diff = {in_donor_value[mmd_pkg::VAL_W-1], in_donor_value}
              - {in_receiver_value[mmd_pkg::VAL_W-1], in_receiver_value};
  assign mag  = diff[mmd_pkg::VAL_W] ? -diff : diff;

  // first pass squares the difference, second pass scales by the weight
  assign mul_start = (accept && numeric) || (state_r == S_MUL1 && mul_done);
  assign mul_a     = (state_r == S_MUL1) ? mul_prod[mmd_pkg::MUL_A_W-1:0]
                                         : mmd_pkg::MUL_A_W'(mag[mmd_pkg::VAL_W-1:0]);

  // saturating sums
  assign dsum_wide = {1'b0, dsum_r} + (mmd_pkg::DSUM_W + 1)'(add_r);
  assign wsum_wide = {1'b0, wsum_r} + (mmd_pkg::WSUM_W + 1)'(contrib_r ? w_r : '0);
  assign dsum_nxt  = dsum_wide[mmd_pkg::DSUM_W] ? '1 : dsum_wide[mmd_pkg::DSUM_W-1:0];
  assign wsum_nxt  = wsum_wide[mmd_pkg::WSUM_W] ? '1 : wsum_wide[mmd_pkg::WSUM_W-1:0];

  assign div_start  = (state_r == S_ADD) && last_r && (wsum_nxt != '0);
  assign sqrt_start = (state_r == S_DIV) && div_done;

  assign emit     = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign root_sat = (|sqrt_root[mmd_pkg::ROOT_W-1:mmd_pkg::DIST_W]) ? '1
                  : sqrt_root[mmd_pkg::DIST_W-1:0];

  mmd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     ((state_r == S_MUL1) ? w_r : mag[mmd_pkg::VAL_W-1:0]),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dsum_nxt),
    .divisor  (wsum_nxt),
    .done     (div_done),
    .quot     (div_quot)
  );

  mmd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dsum_r  <= '0;
      wsum_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) state_r <= numeric ? S_MUL1 : S_ADD;
        end
        S_MUL1: begin
          if (mul_done) state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_done) state_r <= S_ADD;
        end
        S_ADD: begin
          if (last_r) begin
            dsum_r  <= '0;
            wsum_r  <= '0;
            state_r <= (wsum_nxt == '0) ? S_EMIT : S_DIV;
          end else begin
            dsum_r  <= dsum_nxt;
            wsum_r  <= wsum_nxt;
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_r       <= in_weight;
      last_r    <= in_last;
      contrib_r <= contrib;
      // categorical mismatch adds one in q.24 times the weight
      if (contrib && in_kind && (in_receiver_value != in_donor_value))
        add_r <= mmd_pkg::PROD_W'(in_weight) << mmd_pkg::CAT_SHIFT;
      else
        add_r <= '0;
    end else if (state_r == S_MUL2 && mul_done) begin
      add_r <= mul_prod;
    end
    if (state_r == S_ADD) inf_r <= (wsum_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_infinite_r <= inf_r;
      out_distance_r <= inf_r ? '0 : root_sat;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_infinite = out_infinite_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (wsum_nxt != '0))
    else $error("divide started with zero weight sum");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result beat without emit state");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_infinite_r) |-> (out_distance_r == '0))
    else $error("infinite result with nonzero distance");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL1 || state_r == S_MUL2))
    else $error("multiply finished outside multiply states");

  a_sqrt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> (state_r == S_SQRT))
    else $error("square root finished outside its state");

endmodule

### tb/tb_masked_mixed_distance.sv
`timescale 1ns / 100ps

module tb_masked_mixed_distance;

  localparam int MAX_REPORTS = 10;
  localparam int CAT_UNIT    = 24;
  localparam int RANDOM_COLS = 1000;

  typedef struct packed {
    logic                             kind;
    logic signed [mmd_pkg::VAL_W-1:0] rv;
    logic signed [mmd_pkg::VAL_W-1:0] dv;
    logic                             rp;
    logic                             dp;
    logic [mmd_pkg::WGT_W-1:0]        w;
    logic                             skip;
    logic                             last;
  } column_t;

  typedef struct packed {
    logic [mmd_pkg::DIST_W-1:0] distance;
    logic                       infinite;
  } distance_t;

  class row_distance_tracker;
    mmd_pkg::dsum_t dis_sum;
    mmd_pkg::wsum_t wgt_sum;
    distance_t      distances_due[$];
    int             mismatches;

    function new();
      dis_sum    = '0;
      wgt_sum    = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return distances_due.size();
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 27; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void add_column(column_t c);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] root;
      int          gap;
      int          mag;
      distance_t   d;
      if (!c.skip && c.w != 0 && c.rp && c.dp) begin
        if (!c.kind) begin
          gap  = int'(c.dv) - int'(c.rv);
          mag  = (gap < 0) ? -gap : gap;
          term = 64'(mag) * 64'(mag) * 64'(c.w);
        end else begin
          // codes compare as raw bit patterns
          term = (c.rv != c.dv) ? (64'(c.w) << CAT_UNIT) : 64'd0;
        end
        sum     = 64'(dis_sum) + term;
        dis_sum = (sum > 64'({mmd_pkg::DSUM_W{1'b1}})) ? {mmd_pkg::DSUM_W{1'b1}}
                : sum[mmd_pkg::DSUM_W-1:0];
        sum     = 64'(wgt_sum) + 64'(c.w);
        wgt_sum = (sum > 64'({mmd_pkg::WSUM_W{1'b1}})) ? {mmd_pkg::WSUM_W{1'b1}}
                : sum[mmd_pkg::WSUM_W-1:0];
      end
      if (c.last) begin
        if (wgt_sum == 0) begin
          d.distance = '0;
          d.infinite = 1'b1;
        end else begin
          root       = int_sqrt(64'(dis_sum) / 64'(wgt_sum));
          d.distance = (root > 64'(16'hFFFF)) ? 16'hFFFF : root[mmd_pkg::DIST_W-1:0];
          d.infinite = 1'b0;
        end
        distances_due.insert(distances_due.size(), d);
        dis_sum = '0;
        wgt_sum = '0;
      end
    endfunction

    function void match_result(logic [mmd_pkg::DIST_W-1:0] distance, logic infinite);
      distance_t want;
      if (distances_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: distance=%h infinite=%b", distance, infinite);
        return;
      end
      want = distances_due.pop_front();
      if (want.distance !== distance || want.infinite !== infinite) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("distance mismatch: expected %h/%b, got %h/%b",
                   want.distance, want.infinite, distance, infinite);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_kind;
  logic signed [mmd_pkg::VAL_W-1:0] in_receiver_value;
  logic signed [mmd_pkg::VAL_W-1:0] in_donor_value;
  logic                             in_receiver_present;
  logic                             in_donor_present;
  logic [mmd_pkg::WGT_W-1:0]        in_weight;
  logic                             in_skip;
  logic                             in_last;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [mmd_pkg::DIST_W-1:0]       out_distance;
  logic                             out_infinite;

  row_distance_tracker tracker = new();
  bit                  calm = 1'b0;
  int                  columns_sent = 0;

  masked_mixed_distance uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_receiver_value   (in_receiver_value),
    .in_donor_value      (in_donor_value),
    .in_receiver_present (in_receiver_present),
    .in_donor_present    (in_donor_present),
    .in_weight           (in_weight),
    .in_skip             (in_skip),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance        (out_distance),
    .out_infinite        (out_infinite)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.match_result(out_distance, out_infinite);
  end

  function automatic column_t mk(logic kind, logic signed [mmd_pkg::VAL_W-1:0] rv,
                                 logic signed [mmd_pkg::VAL_W-1:0] dv, logic rp, logic dp,
                                 logic [mmd_pkg::WGT_W-1:0] w, logic skip, logic last);
    column_t c;
    c.kind = kind;
    c.rv   = rv;
    c.dv   = dv;
    c.rp   = rp;
    c.dp   = dp;
    c.w    = w;
    c.skip = skip;
    c.last = last;
    return c;
  endfunction

  function automatic logic signed [mmd_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3:       return mmd_pkg::VAL_W'($signed($urandom_range(64)) - 32);
      default: return mmd_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // heavy columns push both sums toward saturation
  function automatic column_t rand_column(bit last, bit heavy);
    column_t c;
    c.kind = heavy ? 1'b0 : 1'($urandom_range(1));
    c.rv   = pick_value();
    c.dv   = pick_value();
    if (heavy) begin
      c.rv = $urandom_range(1) ? 16'sh8000
           : mmd_pkg::VAL_W'($urandom_range(16'h8FFF, 16'h8000));
      c.dv = 16'sh7FFF - mmd_pkg::VAL_W'($urandom_range(15));
    end else if (c.kind && $urandom_range(1)) begin
      c.dv = c.rv;
    end
    c.rp = heavy || ($urandom_range(99) < 88);
    c.dp = heavy || ($urandom_range(99) < 88);
    if (heavy) c.w = mmd_pkg::WGT_W'($urandom_range(16'hFFFF, 16'hF000));
    else begin
      case ($urandom_range(9))
        0:       c.w = '0;
        1:       c.w = 16'hFFFF;
        2, 3:    c.w = mmd_pkg::WGT_W'($urandom_range(16, 1));
        default: c.w = mmd_pkg::WGT_W'($urandom);
      endcase
    end
    c.skip = !heavy && ($urandom_range(99) < 10);
    c.last = last;
    return c;
  endfunction

  task automatic send_column(column_t c);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_kind             = c.kind;
    in_receiver_value   = c.rv;
    in_donor_value      = c.dv;
    in_receiver_present = c.rp;
    in_donor_present    = c.dp;
    in_weight           = c.w;
    in_skip             = c.skip;
    in_last             = c.last;
    in_valid            = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.add_column(c);
    columns_sent++;
  endtask

  // hold the sender off until every row result is back
  task automatic drain_rows();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_row(int cols, bit heavy);
    for (int i = 0; i < cols; i++) send_column(rand_column(i == cols - 1, heavy));
  endtask

  initial begin
    int target;
    int waited;
    bit paused;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = 1'b0;
    in_receiver_value   = '0;
    in_donor_value      = '0;
    in_receiver_present = 1'b0;
    in_donor_present    = 1'b0;
    in_weight           = '0;
    in_skip             = 1'b0;
    in_last             = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-column rows: largest distance, zero distance, each way to be excluded
    send_column(mk(1'b0, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1));
    send_column(mk(1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'h0001, 1'b0, 1'b1));
    send_column(mk(1'b0, 16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1));
    send_column(mk(1'b0, 16'sh1000, 16'sh2000, 1'b1, 1'b1, 16'h1000, 1'b1, 1'b1));
    send_column(mk(1'b0, 16'sh1000, 16'sh2000, 1'b0, 1'b1, 16'h1000, 1'b0, 1'b1));
    send_column(mk(1'b0, 16'sh1000, 16'sh2000, 1'b1, 1'b0, 16'h1000, 1'b0, 1'b1));
    send_column(mk(1'b0, 16'sh1000, 16'sh2000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1));
    // categorical mismatch and match
    send_column(mk(1'b1, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 16'h1000, 1'b0, 1'b1));
    send_column(mk(1'b1, -16'sd1, -16'sd1, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1));
    // mixed row ending in a contributing column
    send_column(mk(1'b0, 16'sh1000, 16'sh3000, 1'b1, 1'b1, 16'h1000, 1'b0, 1'b0));
    send_column(mk(1'b1, 16'sh0005, 16'sh0006, 1'b1, 1'b1, 16'h2000, 1'b0, 1'b0));
    send_column(mk(1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0));
    send_column(mk(1'b1, 16'sh0001, 16'sh0002, 1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0));
    send_column(mk(1'b0, -16'sd3, 16'sh0004, 1'b1, 1'b1, 16'h0800, 1'b0, 1'b1));
    // row whose closing column is skipped but earlier ones count
    send_column(mk(1'b1, 16'sh00AA, 16'sh0055, 1'b1, 1'b1, 16'h3000, 1'b0, 1'b0));
    send_column(mk(1'b0, 16'sh0400, -16'sh0400, 1'b1, 1'b1, 16'h0100, 1'b0, 1'b0));
    send_column(mk(1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
    drain_rows();

    // a long heavy row pushes both sums toward saturation
    target = columns_sent + RANDOM_COLS;
    paused = 1'b0;
    send_row($urandom_range(90, 66), 1'b1);
    while (columns_sent < target) begin
      calm = (columns_sent > target - 650) && (columns_sent < target - 500);
      if (!paused && columns_sent > target - 400) begin
        drain_rows();
        paused = 1'b1;
      end
      if ($urandom_range(39) == 0) send_row($urandom_range(90, 66), $urandom_range(1));
      else send_row($urandom_range(8, 1), 1'b0);
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (150) @(posedge clk);
    tracker.mismatches += tracker.pending();
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
